@@ sv/lex_pkg.sv @@
// Package with the word tables, character codes and class codes of the token classifier.
`timescale 1ns / 1ps

package lex_pkg;

  localparam int NumKeywords  = 16;
  localparam int NumOperators = 11;
  localparam int WordBytes    = 8;
  localparam int LenW         = 4;
  localparam int DotW         = 2;

  localparam logic [LenW-1:0] LenSat = LenW'(WordBytes);
  localparam logic [LenW-1:0] LenMax = LenW'(WordBytes - 1);
  localparam logic [DotW-1:0] DotSat = DotW'(2);

  typedef enum logic [2:0] {
    ClsReserved   = 3'd0,
    ClsInteger    = 3'd1,
    ClsFloat      = 3'd2,
    ClsOperator   = 3'd3,
    ClsIdentifier = 3'd4,
    ClsNewline    = 3'd5,
    ClsError      = 3'd6
  } token_class_e;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharNul   = 8'h00;

  // Words are stored left justified: byte position p sits at bits [8*(7-p) +: 8].
  localparam logic [63:0] KwTable [NumKeywords] = '{
    {"const",   24'h0}, {"int",     40'h0}, {"float",   24'h0}, {"double",  16'h0},
    {"long",    32'h0}, {"static",  16'h0}, {"void",    32'h0}, {"char",    32'h0},
    {"extern",  16'h0}, {"return",  16'h0}, {"break",   24'h0}, {"enum",    32'h0},
    {"struct",  16'h0}, {"typedef",  8'h0}, {"union",   24'h0}, {"goto",    32'h0}
  };

  localparam logic [LenW-1:0] KwLen [NumKeywords] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  localparam logic [63:0] OpTable [NumOperators] = '{
    {"+",  56'h0}, {"-",  56'h0}, {"*",  56'h0}, {"/",  56'h0}, {"=",  56'h0},
    {"==", 48'h0}, {"!=", 48'h0}, {">=", 48'h0}, {"<=", 48'h0},
    {">",  56'h0}, {"<",  56'h0}
  };

  localparam logic [LenW-1:0] OpLen [NumOperators] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
  };

endpackage

@@ sv/lexical_token_classifier.sv @@
// Top level of the lexical token classifier: byte stream in, one class word per token or bare semicolon out.
`timescale 1ns / 1ps

// Channel | Handshake              | Payload
// --------+------------------------+----------------------------------------
// in      | in_valid_i / in_ready_o   | kind_i (1), char_code_i (8)
// out     | out_valid_o / out_ready_i | token_class_o (3), newline_after_o (1)
//
// One word is taken per cycle while in_ready_o is high. A byte is registered at
// the input, then the match flags and the class are worked out from the input
// register and the result goes into the output register. Reset clears both
// stages and the token state. When the output register is full and not taken,
// the input stage holds and in_ready_o drops once it is occupied; nothing is
// dropped or repeated.
module lexical_token_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_class_o,
  output logic       newline_after_o
);

  // Input stage.
  logic       in_valid_q;
  logic       kind_q;
  logic [7:0] char_q;

  // Output stage.
  logic                  out_valid_q, out_valid_d;
  lex_pkg::token_class_e class_q, class_d;
  logic                  newline_q, newline_d;

  // Per-token state.
  logic [lex_pkg::NumKeywords-1:0]  kw_hits_q, kw_hits_d;
  logic [lex_pkg::NumOperators-1:0] op_hits_q, op_hits_d;
  logic [lex_pkg::LenW-1:0]         tok_len_q, tok_len_d;
  logic [lex_pkg::DotW-1:0]         dot_cnt_q, dot_cnt_d;
  logic only_digits_q, only_digits_d;
  logic digit_dots_q, digit_dots_d;
  logic ident_q, ident_d;
  logic first_digit_q, first_digit_d;
  logic failed_q, failed_d;

  logic advance, consume;
  logic is_digit, is_dot, is_alpha, is_space, is_semi, is_end, pending;
  logic kw_word_hit, op_word_hit;
  logic [2:0] pos;
  logic       pos_ok;
  lex_pkg::token_class_e tok_class;

  // The output register can be loaded when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign consume    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  assign is_digit = (char_q >= "0") && (char_q <= "9");
  assign is_dot   = (char_q == lex_pkg::CharDot);
  assign is_alpha = ((char_q >= "A") && (char_q <= "Z")) ||
                    ((char_q >= "a") && (char_q <= "z")) || (char_q == "_");
  assign is_space = (char_q == lex_pkg::CharSpace) ||
                    ((char_q >= lex_pkg::CharTab) && (char_q <= lex_pkg::CharCr));
  assign is_semi  = (char_q == lex_pkg::CharSemi);
  assign is_end   = (kind_q == lex_pkg::KindEnd);
  assign pending  = (tok_len_q != '0);

  // Table words are at most seven bytes, so a byte at position seven or later
  // knocks out every word; position then fits in three bits.
  assign pos    = tok_len_q[2:0];
  assign pos_ok = (tok_len_q < lex_pkg::LenMax);

  // A word still flagged after len bytes matches exactly when its length is len.
  always_comb begin
    kw_word_hit = 1'b0;
    for (int i = 0; i < lex_pkg::NumKeywords; i++) begin
      if (kw_hits_q[i] && (tok_len_q == lex_pkg::KwLen[i])) begin
        kw_word_hit = 1'b1;
      end
    end
    op_word_hit = 1'b0;
    for (int i = 0; i < lex_pkg::NumOperators; i++) begin
      if (op_hits_q[i] && (tok_len_q == lex_pkg::OpLen[i])) begin
        op_word_hit = 1'b1;
      end
    end
  end

  // Class of the pending token, in priority order.
  always_comb begin
    if (kw_word_hit) begin
      tok_class = lex_pkg::ClsReserved;
    end else if (only_digits_q) begin
      tok_class = lex_pkg::ClsInteger;
    end else if (digit_dots_q && (dot_cnt_q < lex_pkg::DotSat)) begin
      tok_class = lex_pkg::ClsFloat;
    end else if (op_word_hit) begin
      tok_class = lex_pkg::ClsOperator;
    end else if (ident_q && !first_digit_q) begin
      tok_class = lex_pkg::ClsIdentifier;
    end else begin
      tok_class = lex_pkg::ClsError;
    end
  end

  always_comb begin
    kw_hits_d     = kw_hits_q;
    op_hits_d     = op_hits_q;
    tok_len_d     = tok_len_q;
    dot_cnt_d     = dot_cnt_q;
    only_digits_d = only_digits_q;
    digit_dots_d  = digit_dots_q;
    ident_d       = ident_q;
    first_digit_d = first_digit_q;
    failed_d      = failed_q;
    out_valid_d   = out_valid_q;
    class_d       = class_q;
    newline_d     = newline_q;

    if (advance) begin
      out_valid_d = 1'b0;
    end

    if (consume && !failed_q) begin
      if (is_end || is_space || is_semi) begin
        if (pending) begin
          // Token closed: report its class and start a fresh token.
          out_valid_d   = 1'b1;
          class_d       = tok_class;
          newline_d     = is_semi && !is_end && !is_space;
          kw_hits_d     = '1;
          op_hits_d     = '1;
          tok_len_d     = '0;
          dot_cnt_d     = '0;
          only_digits_d = 1'b1;
          digit_dots_d  = 1'b1;
          ident_d       = 1'b1;
          first_digit_d = 1'b0;
          if (tok_class == lex_pkg::ClsError) begin
            failed_d  = 1'b1;
            newline_d = 1'b0;
          end
        end else if (is_semi && !is_end) begin
          // A bare semicolon still ends a line.
          out_valid_d = 1'b1;
          class_d     = lex_pkg::ClsNewline;
          newline_d   = 1'b1;
        end
      end else begin
        for (int i = 0; i < lex_pkg::NumKeywords; i++) begin
          if ((char_q == lex_pkg::CharNul) || !pos_ok ||
              (lex_pkg::KwTable[i][8*(7-int'(pos)) +: 8] != char_q)) begin
            kw_hits_d[i] = 1'b0;
          end
        end
        for (int i = 0; i < lex_pkg::NumOperators; i++) begin
          if ((char_q == lex_pkg::CharNul) || !pos_ok ||
              (lex_pkg::OpTable[i][8*(7-int'(pos)) +: 8] != char_q)) begin
            op_hits_d[i] = 1'b0;
          end
        end
        if (!pending && is_digit) begin
          first_digit_d = 1'b1;
        end
        if (!is_digit) begin
          only_digits_d = 1'b0;
        end
        if (!is_digit && !is_dot) begin
          digit_dots_d = 1'b0;
        end
        if (is_dot && (dot_cnt_q < lex_pkg::DotSat)) begin
          dot_cnt_d = dot_cnt_q + 1'b1;
        end
        if (!is_digit && !is_alpha) begin
          ident_d = 1'b0;
        end
        if (tok_len_q < lex_pkg::LenSat) begin
          tok_len_d = tok_len_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      kw_hits_q     <= '1;
      op_hits_q     <= '1;
      tok_len_q     <= '0;
      dot_cnt_q     <= '0;
      only_digits_q <= 1'b1;
      digit_dots_q  <= 1'b1;
      ident_q       <= 1'b1;
      first_digit_q <= 1'b0;
      failed_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q   <= out_valid_d;
      kw_hits_q     <= kw_hits_d;
      op_hits_q     <= op_hits_d;
      tok_len_q     <= tok_len_d;
      dot_cnt_q     <= dot_cnt_d;
      only_digits_q <= only_digits_d;
      digit_dots_q  <= digit_dots_d;
      ident_q       <= ident_d;
      first_digit_q <= first_digit_d;
      failed_q      <= failed_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
    end
    class_q   <= class_d;
    newline_q <= newline_d;
  end

  assign out_valid_o     = out_valid_q;
  assign token_class_o   = class_q;
  assign newline_after_o = newline_q;

endmodule
